// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands for the color converter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/rycc_pkg.sv =====
// ---------------------------------------------------------------------------
// rycc_pkg
// Types, fixed-point widths and coefficient tables of the color converter.
// ---------------------------------------------------------------------------
`default_nettype none

package rycc_pkg;

    localparam int FRAC_BITS = 16;

    localparam int PIX_W  = 8;
    localparam int OPND_W = PIX_W + 1;            // signed operand: pixel or chroma - 128
    localparam int COEF_W = FRAC_BITS + 3;        // signed, magnitude below 2.0
    localparam int PROD_W = COEF_W + OPND_W;
    localparam int SUM_W  = PROD_W + 2;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef opnd_t [2:0] opnd_vec_t;
    typedef prod_t [2:0] prod_row_t;
    typedef prod_row_t [2:0] prod_mat_t;
    typedef sum_t [2:0] sum_vec_t;
    typedef pix_t [2:0] pix_vec_t;

    // Control that travels alongside each pixel through the pipeline
    typedef struct packed {
        logic valid;
        logic mode;     // 0: RGB to YUV, 1: YUV to RGB
        logic last;
    } ctrl_t;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_REV = 1'b1;

    localparam longint SCALE = longint'(1) <<< FRAC_BITS;
    localparam longint MICRO = 1000000;
    localparam longint RND   = 500000;

    // round(value * 2^FRAC_BITS), value given in millionths
    localparam longint K_Y_R = (longint'(299000)  * SCALE + RND) / MICRO;
    localparam longint K_Y_G = (longint'(587000)  * SCALE + RND) / MICRO;
    localparam longint K_Y_B = (longint'(114000)  * SCALE + RND) / MICRO;
    localparam longint K_U_R = (longint'(168736)  * SCALE + RND) / MICRO;
    localparam longint K_U_G = (longint'(331264)  * SCALE + RND) / MICRO;
    localparam longint K_HLF = (longint'(500000)  * SCALE + RND) / MICRO;
    localparam longint K_V_G = (longint'(418688)  * SCALE + RND) / MICRO;
    localparam longint K_V_B = (longint'(81312)   * SCALE + RND) / MICRO;
    localparam longint K_R_V = (longint'(1402000) * SCALE + RND) / MICRO;
    localparam longint K_G_U = (longint'(344140)  * SCALE + RND) / MICRO;
    localparam longint K_G_V = (longint'(714140)  * SCALE + RND) / MICRO;
    localparam longint K_B_U = (longint'(1771800) * SCALE + RND) / MICRO;

    // Rows: output channel; columns: operand channel
    localparam coef_t COEF_FWD [3][3] = '{
        '{coef_t'(K_Y_R),  coef_t'(K_Y_G),  coef_t'(K_Y_B)},
        '{coef_t'(-K_U_R), coef_t'(-K_U_G), coef_t'(K_HLF)},
        '{coef_t'(K_HLF),  coef_t'(-K_V_G), coef_t'(-K_V_B)}
    };

    // Reverse operands are Y, U-128, V-128; Y enters at unit gain
    localparam coef_t COEF_REV [3][3] = '{
        '{coef_t'(SCALE), coef_t'(0),      coef_t'(K_R_V)},
        '{coef_t'(SCALE), coef_t'(-K_G_U), coef_t'(-K_G_V)},
        '{coef_t'(SCALE), coef_t'(K_B_U),  coef_t'(0)}
    };

    localparam sum_t HALF_OFS = sum_t'(longint'(128) * SCALE);
    localparam sum_t BASE_FWD [3] = '{sum_t'(0), HALF_OFS, HALF_OFS};

    localparam opnd_t CHROMA_BIAS = opnd_t'(128);

endpackage

`default_nettype wire

// ===== rtl/core/rycc_operand_stage.sv =====
// ---------------------------------------------------------------------------
// rycc_operand_stage
// Register the pixel and form signed operands for the selected direction.
// ---------------------------------------------------------------------------
`default_nettype none

module rycc_operand_stage import rycc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  wire ctrl_t     ctrl_in,
    input  wire pix_vec_t  pix_in,
    output ctrl_t          ctrl_out,
    output opnd_vec_t      opnd_out
);

    ctrl_t     ctrl_reg;
    opnd_vec_t opnd_reg, opnd_next;

    always_comb begin
        opnd_next[0] = opnd_t'({1'b0, pix_in[0]});
        if (ctrl_in.mode == DIR_REV) begin
            opnd_next[1] = opnd_t'({1'b0, pix_in[1]}) - CHROMA_BIAS;
            opnd_next[2] = opnd_t'({1'b0, pix_in[2]}) - CHROMA_BIAS;
        end else begin
            opnd_next[1] = opnd_t'({1'b0, pix_in[1]});
            opnd_next[2] = opnd_t'({1'b0, pix_in[2]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            opnd_reg <= opnd_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign opnd_out = opnd_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rycc_mult_stage.sv =====
// ---------------------------------------------------------------------------
// rycc_mult_stage
// Nine constant-coefficient products, coefficients chosen by direction.
// ---------------------------------------------------------------------------
`default_nettype none

module rycc_mult_stage import rycc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  wire ctrl_t     ctrl_in,
    input  wire opnd_vec_t opnd_in,
    output ctrl_t          ctrl_out,
    output prod_mat_t      prod_out
);

    ctrl_t     ctrl_reg;
    prod_mat_t prod_reg, prod_next;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r][c] = prod_t'((ctrl_in.mode == DIR_REV) ? COEF_REV[r][c]
                                                                    : COEF_FWD[r][c])
                                * prod_t'($signed(opnd_in[c]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign prod_out = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rycc_sum_stage.sv =====
// ---------------------------------------------------------------------------
// rycc_sum_stage
// Add each row of products plus the chroma offset in forward mode.
// ---------------------------------------------------------------------------
`default_nettype none

module rycc_sum_stage import rycc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  wire ctrl_t     ctrl_in,
    input  wire prod_mat_t prod_in,
    output ctrl_t          ctrl_out,
    output sum_vec_t       sum_out
);

    ctrl_t    ctrl_reg;
    sum_vec_t sum_reg, sum_next;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum_next[r] = sum_t'($signed(prod_in[r][0])) + sum_t'($signed(prod_in[r][1]))
                        + sum_t'($signed(prod_in[r][2]))
                        + ((ctrl_in.mode == DIR_FWD) ? BASE_FWD[r] : sum_t'(0));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sum_reg <= sum_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign sum_out  = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rycc_clamp_stage.sv =====
// ---------------------------------------------------------------------------
// rycc_clamp_stage
// Floor each fixed-point sum and saturate it to 0..255; output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rycc_clamp_stage import rycc_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire ctrl_t    ctrl_in,
    input  wire sum_vec_t sum_in,
    output ctrl_t         ctrl_out,
    output pix_vec_t      pix_out
);

    ctrl_t    ctrl_reg;
    pix_vec_t pix_reg, pix_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            priority if (sum_in[k][SUM_W-1]) begin
                pix_next[k] = '0;
            end else if (|sum_in[k][SUM_W-2:FRAC_BITS+PIX_W]) begin
                pix_next[k] = '1;
            end else begin
                pix_next[k] = sum_in[k][FRAC_BITS+PIX_W-1:FRAC_BITS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pix_reg <= pix_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign pix_out  = pix_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rgb_ycbcr_color_converter_unit.sv =====
// Path: an accepted input beat passes the operand, multiply, sum and clamp register
// stages in turn. Throughput: one pixel per clock unless m_tready stalls the output;
// each stage refills as soon as it hands on.
// Reset (aresetn low, synchronous): drop all beats in flight, direction = RGB to YUV.
// ---------------------------------------------------------------------------
// rgb_ycbcr_color_converter_unit
// BT.601 RGB <-> YUV pixel converter, Q.16 fixed point, saturated 8-bit out.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgb_ycbcr_color_converter_unit import rycc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Direction register write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,      // [0] direction

    // Input pixel stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // [7:0] in_c0, [15:8] in_c1, [23:16] in_c2
    input  wire logic        s_tlast,       // in_last

    // Output pixel stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,       // [7:0] out_c0, [15:8] out_c1, [23:16] out_c2
    output logic             m_tlast        // out_last
);

    // Direction register: always ready; writes must come only while idle (unenforced)
    logic direction_reg, direction_next;

    assign cfg_ready      = 1'b1;
    assign direction_next = cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_FWD;
        end else if (cfg_valid && cfg_ready) begin
            direction_reg <= direction_next;
        end
    end

    // Pipeline control: each stage advances when empty or when the next one advances
    ctrl_t ctrl_in, ctrl_opnd, ctrl_mult, ctrl_sum, ctrl_out;
    logic  adv_opnd, adv_mult, adv_sum, adv_out;

    assign adv_out  = !ctrl_out.valid  || m_tready;
    assign adv_sum  = !ctrl_sum.valid  || adv_out;
    assign adv_mult = !ctrl_mult.valid || adv_sum;
    assign adv_opnd = !ctrl_opnd.valid || adv_mult;

    assign s_tready = adv_opnd;

    // Tag each beat with the direction in force when it enters
    assign ctrl_in = '{valid: s_tvalid, mode: direction_reg, last: s_tlast};

    pix_vec_t  pix_in;
    opnd_vec_t opnd;
    prod_mat_t prod;
    sum_vec_t  sums;
    pix_vec_t  pix_res;

    assign pix_in = {s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]};

    // Stage 1: operands (chroma re-centered in reverse mode)
    rycc_operand_stage u_operand (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (adv_opnd),
        .ctrl_in  (ctrl_in),
        .pix_in   (pix_in),
        .ctrl_out (ctrl_opnd),
        .opnd_out (opnd)
    );

    // Stage 2: coefficient products
    rycc_mult_stage u_mult (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (adv_mult),
        .ctrl_in  (ctrl_opnd),
        .opnd_in  (opnd),
        .ctrl_out (ctrl_mult),
        .prod_out (prod)
    );

    // Stage 3: row sums with offset
    rycc_sum_stage u_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (adv_sum),
        .ctrl_in  (ctrl_mult),
        .prod_in  (prod),
        .ctrl_out (ctrl_sum),
        .sum_out  (sums)
    );

    // Stage 4: floor, saturate; this is the output register
    rycc_clamp_stage u_clamp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (adv_out),
        .ctrl_in  (ctrl_sum),
        .sum_in   (sums),
        .ctrl_out (ctrl_out),
        .pix_out  (pix_res)
    );

    assign m_tvalid = ctrl_out.valid;
    assign m_tlast  = ctrl_out.last;
    assign m_tdata  = {pix_res[2], pix_res[1], pix_res[0]};

    // Back-pressure at the input comes only from a stalled output beat
    `ASSERT_IMPL(a_stall_source, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    // An accepted beat lands in the operand stage
    `ASSERT_NEXT(a_accept_lands, aclk, aresetn, s_tvalid && s_tready, ctrl_opnd.valid)
    // A held stage keeps its beat until the next stage takes it
    `ASSERT_NEXT(a_mult_hold, aclk, aresetn, ctrl_mult.valid && !adv_sum,
        ctrl_mult.valid && $stable(prod))

endmodule

`default_nettype wire

// ===== tb/rycc_pixel_checker.sv =====
// ---------------------------------------------------------------------------
// rycc_pixel_checker
// Watches the direction write channel and both pixel streams of the color
// converter, predicts each output pixel from the accepted input beat and the
// current direction, and compares the output stream in order.
// ---------------------------------------------------------------------------
module rycc_pixel_checker import rycc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending,
    output int          beats_checked
);

    localparam longint ONE = longint'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic last;
        pix_t c2;
        pix_t c1;
        pix_t c0;
    } pixel_t;

    pixel_t expected_pixels [$];
    logic   direction;
    pixel_t want;

    // Round a coefficient given in millionths to Q.FRAC_BITS, sign kept apart
    function automatic longint to_fixed(longint micro);
        longint mag;
        longint q;
        mag = (micro < 0) ? -micro : micro;
        q   = (mag * ONE + 500000) / 1000000;
        return (micro < 0) ? -q : q;
    endfunction

    // Floor to an integer, then clamp to the pixel range
    function automatic pix_t saturate(longint acc);
        longint whole;
        if (acc < 0)
            return '0;
        whole = acc >>> FRAC_BITS;
        return (whole > 255) ? pix_t'(255) : pix_t'(whole);
    endfunction

    function automatic pixel_t convert_pixel(logic dir, logic [23:0] data, logic last);
        longint a, b, c, s0, s1, s2, bias, luma, u, v;
        pixel_t px;
        a    = {56'd0, data[7:0]};
        b    = {56'd0, data[15:8]};
        c    = {56'd0, data[23:16]};
        bias = 128 * ONE;
        if (dir == DIR_FWD) begin
            s0 = to_fixed(299000) * a + to_fixed(587000) * b + to_fixed(114000) * c;
            s1 = to_fixed(-168736) * a + to_fixed(-331264) * b + to_fixed(500000) * c + bias;
            s2 = to_fixed(500000) * a + to_fixed(-418688) * b + to_fixed(-81312) * c + bias;
        end else begin
            luma = a * ONE;
            u    = b - 128;
            v    = c - 128;
            s0   = luma + to_fixed(1402000) * v;
            s1   = luma + to_fixed(-344140) * u + to_fixed(-714140) * v;
            s2   = luma + to_fixed(1771800) * u;
        end
        px.c0   = saturate(s0);
        px.c1   = saturate(s1);
        px.c2   = saturate(s2);
        px.last = last;
        return px;
    endfunction

    task automatic report(string what, int got, int exp_val);
        $display("MISMATCH at output beat %0d: %s got %0d, expected %0d",
                 beats_checked, what, got, exp_val);
        mismatches++;
    endtask

    initial begin
        mismatches    = 0;
        pending       = 0;
        beats_checked = 0;
        direction     = DIR_FWD;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_pixels.delete();
            direction = DIR_FWD;
        end else begin
            // Predict with the direction in force before any write at this edge
            if (s_tvalid && s_tready)
                expected_pixels.push_back(convert_pixel(direction, s_tdata, s_tlast));
            if (cfg_valid && cfg_ready)
                direction = cfg_data;
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report("beat with no pixel pending, tdata", int'(m_tdata), -1);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[7:0] !== want.c0)
                        report("out_c0", int'(m_tdata[7:0]), int'(want.c0));
                    if (m_tdata[15:8] !== want.c1)
                        report("out_c1", int'(m_tdata[15:8]), int'(want.c1));
                    if (m_tdata[23:16] !== want.c2)
                        report("out_c2", int'(m_tdata[23:16]), int'(want.c2));
                    if (m_tlast !== want.last)
                        report("out_last", int'(m_tlast), int'(want.last));
                    beats_checked++;
                end
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ===== tb/rgb_ycbcr_color_converter_unit_tb.sv =====
// ---------------------------------------------------------------------------
// rgb_ycbcr_color_converter_unit_tb
// Drives the color converter with directed corner pixels in both directions,
// then with random phases of pixels under random direction settings, random
// idle bursts on both streams, a long output hold-off and a full drain. The
// checker beside the block predicts and compares every output beat.
// ---------------------------------------------------------------------------
module rgb_ycbcr_color_converter_unit_tb;
    import rycc_pkg::*;

    localparam int LATENCY     = 4;     // input beat to output beat
    localparam int SETTLE      = 4 * LATENCY;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int IDLE_LIMIT  = 2000;  // cycles with no beat on any channel
    localparam int PHASES      = 7;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_data;
    logic        s_tvalid;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        m_tready;
    wire         cfg_ready;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;
    wire         m_tlast;

    int mismatches;
    int pending;
    int beats_checked;

    // Shared between the stimulus and the receiver process
    int idle_pct;       // chance in percent that either side starts an idle burst
    bit rx_hold_req;    // ask the receiver for one long hold-off
    int pixels_sent;
    int cfg_writes;

    rgb_ycbcr_color_converter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),       // [7:0] in_c0, [15:8] in_c1, [23:16] in_c2
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),       // [7:0] out_c0, [15:8] out_c1, [23:16] out_c2
        .m_tlast   (m_tlast)
    );

    rycc_pixel_checker pixel_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: drive m_tready once per falling edge. Honor a hold-off request
    // first, else maybe start an idle burst, else accept.
    initial begin
        m_tready = 1'b0;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                repeat ($urandom_range(1, 8)) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end else begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run once no channel has moved a beat for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no beat accepted for %0d cycles, %0d pixels pending",
                 IDLE_LIMIT, pending);
        $display("Some tests failed");
        $finish;
    end

    // Offer one pixel beat, maybe after an idle burst, and hold it until taken
    task automatic send_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2, logic last);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {c2, c1, c0};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    // Stop offering, wait for every pending pixel, then let the pipeline settle
    task automatic drain_pixels();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Write the direction register with the block idle
    task automatic write_direction(logic dir);
        drain_pixels();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= dir;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Lean on the extremes and on the chroma midpoint now and then
    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(120, 136));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin : stimulus
        int   n_items;
        logic dir;
        logic start_dir;

        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        idle_pct    = 0;
        rx_hold_req = 1'b0;
        pixels_sent = 0;
        cfg_writes  = 0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Forward corners at the reset direction: black, white, primaries, mixes
        idle_pct = 20;
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1);

        // Reverse corners: sums driven below zero and past 255 on each channel
        write_direction(DIR_REV);
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0,   8'd128, 8'd128, 1'b0);
        send_pixel(8'd255, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd128, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd128, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd16,  8'd128, 8'd255, 1'b0);
        send_pixel(8'd235, 8'd255, 8'd128, 1'b1);

        // Random phases, each under its own direction, alternating
        start_dir = 1'($urandom_range(0, 1));
        for (int p = 0; p < PHASES; p++) begin
            dir = start_dir ^ p[0];
            write_direction(dir);
            case (p % 3)
                0:       idle_pct = 25;
                1:       idle_pct = 5;
                default: idle_pct = 50;
            endcase
            // Keep the final phase free of idling on both sides
            if (p == PHASES - 1)
                idle_pct = 0;
            n_items = $urandom_range(128, 144);
            for (int i = 0; i < n_items; i++) begin
                // Fill the pipeline against a stalled receiver
                if (p == 2 && i == 20)
                    rx_hold_req = 1'b1;
                // Pause the sender mid-phase until every result is back
                if (p == 4 && i == n_items / 2)
                    drain_pixels();
                send_pixel(rand_channel(), rand_channel(), rand_channel(),
                           $urandom_range(0, 15) == 0);
            end
        end

        drain_pixels();

        $display("Run covered %0d pixel beats (%0d checked) over %0d direction writes,",
                 pixels_sent, beats_checked, cfg_writes);
        $display("both directions, clamp corners, idle bursts, a long hold-off and a drain.");
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== rgb_ycbcr_color_converter_unit.f =====
+incdir+rtl/core
rtl/core/rycc_pkg.sv
rtl/core/rycc_operand_stage.sv
rtl/core/rycc_mult_stage.sv
rtl/core/rycc_sum_stage.sv
rtl/core/rycc_clamp_stage.sv
rtl/core/rgb_ycbcr_color_converter_unit.sv
tb/rycc_pixel_checker.sv
tb/rgb_ycbcr_color_converter_unit_tb.sv
